/* rtl/mcm_pkg.sv */
// Package for the masked cell mean block: widths, register indexes, reset
// values, controller states and the command/status records.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcm_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int COUNT_W      = 13;
    localparam int PERMILLE_W   = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int TDATA_OUT_W  = 32;

    localparam int MAX_CELL_SAMPLES_DEF = 4096;

    localparam logic [PERMILLE_W-1:0] PERMILLE_SCALE = 10'd1000;

    localparam logic signed [SAMPLE_W-1:0] IN_FILL_RST  = -16'sd32768;
    localparam logic signed [SAMPLE_W-1:0] OUT_FILL_RST = -16'sd32767;
    localparam logic [PERMILLE_W-1:0]      KEEP_RST     = 10'd900;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_FILL  = 2'd0,
        CFG_OUT_FILL = 2'd1,
        CFG_KEEP     = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_PROD,
        ST_DIV,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic sample;    // accumulate a non-empty sample
        logic empty;     // empty-cell mark: drop the cell, result is fill
        logic prod;      // register the coverage products, load the divider
        logic div_step;  // one restoring division step
        logic load_out;  // move the finished result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;  // the current division step is the last one
        logic out_free;  // output register can take a result this cycle
    } stat_t;

endpackage

`default_nettype wire

/* rtl/mcm_ctrl.sv */
// Controller of the masked cell mean block: cell state machine that drives
// the datapath commands. Depends on mcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcm_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic          in_last,
    input  wire logic          in_empty,
    output logic               in_ready,
    input  wire mcm_pkg::stat_t stat,
    output mcm_pkg::cmd_t      cmd
);

    mcm_pkg::state_t state_reg, state_next;
    logic            accept;

    assign in_ready = (state_reg == mcm_pkg::ST_ACC);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mcm_pkg::ST_ACC;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mcm_pkg::ST_ACC: begin
                if (accept && in_empty) begin
                    state_next = mcm_pkg::ST_FIN;
                end else if (accept && in_last) begin
                    state_next = mcm_pkg::ST_PROD;
                end
            end
            mcm_pkg::ST_PROD: begin
                state_next = mcm_pkg::ST_DIV;
            end
            mcm_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    state_next = mcm_pkg::ST_FIN;
                end
            end
            mcm_pkg::ST_FIN: begin
                if (stat.out_free) begin
                    state_next = mcm_pkg::ST_ACC;
                end
            end
            default: begin
                state_next = mcm_pkg::ST_ACC;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.sample   = accept && !in_empty;
        cmd.empty    = accept && in_empty;
        cmd.prod     = (state_reg == mcm_pkg::ST_PROD);
        cmd.div_step = (state_reg == mcm_pkg::ST_DIV);
        cmd.load_out = (state_reg == mcm_pkg::ST_FIN) && stat.out_free;
    end

endmodule

`default_nettype wire

/* rtl/mcm_datapath.sv */
// Datapath of the masked cell mean block: accumulators, coverage products,
// restoring divider and output register. Depends on mcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcm_datapath #(
    parameter int MAX_CELL_SAMPLES = mcm_pkg::MAX_CELL_SAMPLES_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire mcm_pkg::cmd_t                          cmd,
    output mcm_pkg::stat_t                              stat,
    input  wire logic signed [mcm_pkg::SAMPLE_W-1:0]    depth_sample,
    input  wire logic signed [mcm_pkg::SAMPLE_W-1:0]    in_fill,
    input  wire logic signed [mcm_pkg::SAMPLE_W-1:0]    out_fill,
    input  wire logic [mcm_pkg::PERMILLE_W-1:0]         keep_permille,
    input  wire logic                                   out_ready,
    output logic                                        out_valid,
    output logic signed [mcm_pkg::SAMPLE_W-1:0]         out_mean,
    output logic [mcm_pkg::COUNT_W-1:0]                 out_count,
    output logic                                        out_fill_flag
);

    localparam int TALLY_W = $clog2(MAX_CELL_SAMPLES + 1);
    localparam int MAG_W   = TALLY_W + 15;
    localparam int PROD_W  = TALLY_W + mcm_pkg::PERMILLE_W;
    localparam int STEP_W  = $clog2(MAG_W);
    localparam logic [TALLY_W-1:0] MAX_T  = TALLY_W'(MAX_CELL_SAMPLES);
    localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(MAG_W - 1);

    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic [TALLY_W-1:0] vt_reg, vt_next;
    logic [TALLY_W-1:0] st_reg, st_next;
    logic               empty_reg, empty_next;
    logic [PROD_W-1:0]  have_reg, need_reg;
    logic [MAG_W-1:0]   quo_reg, quo_next;
    logic [TALLY_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               ovalid_reg, ovalid_next;
    logic signed [mcm_pkg::SAMPLE_W-1:0] mean_reg;
    logic [mcm_pkg::COUNT_W-1:0]         count_reg;
    logic                                fill_reg;

    logic [mcm_pkg::SAMPLE_W-1:0] sample_mag;
    logic                         sample_ok;
    logic [TALLY_W:0]             trial;
    logic                         trial_ge;
    logic [MAG_W-1:0]             neg_quo;
    logic                         res_fill;

    // A sample counts when it is negative and is not the missing-data code.
    assign sample_ok  = depth_sample[mcm_pkg::SAMPLE_W-1] && (depth_sample != in_fill);
    assign sample_mag = (~depth_sample) + mcm_pkg::SAMPLE_W'(1);

    assign trial    = {rem_reg, quo_reg[MAG_W-1]};
    assign trial_ge = (trial >= {1'b0, vt_reg});
    assign neg_quo  = (~quo_reg) + MAG_W'(1);
    assign res_fill = empty_reg || (vt_reg == '0) || (have_reg < need_reg);

    assign stat.div_done = (step_reg == LAST_STEP);
    assign stat.out_free = !ovalid_reg || out_ready;

    always_comb begin
        mag_next   = mag_reg;
        vt_next    = vt_reg;
        st_next    = st_reg;
        empty_next = empty_reg;
        if (cmd.empty || cmd.load_out) begin
            mag_next   = '0;
            vt_next    = '0;
            st_next    = '0;
            empty_next = cmd.empty;
        end else if (cmd.sample && (st_reg < MAX_T)) begin
            st_next = st_reg + TALLY_W'(1);
            if (sample_ok) begin
                mag_next = mag_reg + MAG_W'(sample_mag);
                vt_next  = vt_reg + TALLY_W'(1);
            end
        end
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.prod) begin
            quo_next  = mag_reg;
            rem_next  = '0;
            step_next = '0;
        end else if (cmd.div_step) begin
            quo_next  = {quo_reg[MAG_W-2:0], trial_ge};
            rem_next  = trial_ge ? TALLY_W'(trial - {1'b0, vt_reg}) : trial[TALLY_W-1:0];
            step_next = step_reg + STEP_W'(1);
        end
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        if (cmd.load_out) begin
            ovalid_next = 1'b1;
        end else if (out_ready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg    <= '0;
            vt_reg     <= '0;
            st_reg     <= '0;
            empty_reg  <= 1'b0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            mag_reg    <= mag_next;
            vt_reg     <= vt_next;
            st_reg     <= st_next;
            empty_reg  <= empty_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (cmd.prod) begin
            have_reg <= PROD_W'(vt_reg) * PROD_W'(mcm_pkg::PERMILLE_SCALE);
            need_reg <= PROD_W'(keep_permille) * PROD_W'(st_reg);
        end
        if (cmd.load_out) begin
            mean_reg  <= res_fill ? out_fill : neg_quo[mcm_pkg::SAMPLE_W-1:0];
            count_reg <= res_fill && (have_reg >= need_reg) ? '0 :
                         mcm_pkg::COUNT_W'(vt_reg);
            fill_reg  <= res_fill;
        end
    end

    assign out_valid     = ovalid_reg;
    assign out_mean      = mean_reg;
    assign out_count     = count_reg;
    assign out_fill_flag = fill_reg;

    // The valid tally never runs ahead of the sample tally.
    a_tally_order: assert property (@(posedge aclk) disable iff (!aresetn)
        vt_reg <= st_reg)
        else $error("valid tally exceeds sample tally");

    // Sample tally saturates at the cell limit.
    a_tally_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg <= MAX_T)
        else $error("sample tally past the cell limit");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> ovalid_reg)
        else $error("loaded result not presented");

    // A result is only loaded when the output register can take it.
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!ovalid_reg || out_ready))
        else $error("result loaded over a pending one");

endmodule

`default_nettype wire

/* rtl/masked_cell_mean_with_coverage_top.sv */
// Top level of the masked cell mean block: ports, configuration registers,
// and the controller and datapath. Depends on mcm_pkg, mcm_ctrl, mcm_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    s_tdata depth_sample, s_tlast, s_tuser empty_cell
// m_*       out  m_tvalid / m_tready    m_tdata mean_depth + valid_count, m_tuser is_fill
// cfg_*     in   cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// A sample request is taken every cycle while a cell gathers. After the last
// sample of a cell the block runs the coverage products, the restoring divider
// (one quotient bit per cycle, MAG_W = clog2(MAX_CELL_SAMPLES+1)+15 bits, 28 at
// the default) and the hand-off of the result to the output register, during none
// of which a sample is taken. An empty-cell request goes straight to the hand-off.
// The result waits only if the output register is still held by the consumer.
// Reset is synchronous and active low, needs no clearing pass, and restores the
// configuration registers to their defaults.

module masked_cell_mean_with_coverage_top #(
    parameter int MAX_CELL_SAMPLES = mcm_pkg::MAX_CELL_SAMPLES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // Sample input channel.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [mcm_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] depth_sample
    input  wire logic                              s_tlast,   // last_in_cell
    input  wire logic [0:0]                        s_tuser,   // [0] empty_cell
    // Result output channel.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [mcm_pkg::TDATA_OUT_W-1:0]        m_tdata,   // [15:0] mean_depth,
                                                              // [28:16] valid_count,
                                                              // [31:29] zero
    output logic [0:0]                             m_tuser,   // [0] is_fill
    // Configuration write channel.
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mcm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic signed [mcm_pkg::SAMPLE_W-1:0] in_fill_reg, in_fill_next;
    logic signed [mcm_pkg::SAMPLE_W-1:0] out_fill_reg, out_fill_next;
    logic [mcm_pkg::PERMILLE_W-1:0]      keep_reg, keep_next;

    mcm_pkg::cmd_t  cmd;
    mcm_pkg::stat_t stat;

    logic signed [mcm_pkg::SAMPLE_W-1:0] res_mean;
    logic [mcm_pkg::COUNT_W-1:0]         res_count;
    logic                                res_fill;

    // Configuration writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        in_fill_next  = in_fill_reg;
        out_fill_next = out_fill_reg;
        keep_next     = keep_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mcm_pkg::CFG_IN_FILL:  in_fill_next  = cfg_data;
                mcm_pkg::CFG_OUT_FILL: out_fill_next = cfg_data;
                mcm_pkg::CFG_KEEP:     keep_next     = cfg_data[mcm_pkg::PERMILLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_fill_reg  <= mcm_pkg::IN_FILL_RST;
            out_fill_reg <= mcm_pkg::OUT_FILL_RST;
            keep_reg     <= mcm_pkg::KEEP_RST;
        end else begin
            in_fill_reg  <= in_fill_next;
            out_fill_reg <= out_fill_next;
            keep_reg     <= keep_next;
        end
    end

    mcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_empty (s_tuser[0]),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcm_datapath #(
        .MAX_CELL_SAMPLES (MAX_CELL_SAMPLES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .depth_sample  (s_tdata),
        .in_fill       (in_fill_reg),
        .out_fill      (out_fill_reg),
        .keep_permille (keep_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_mean      (res_mean),
        .out_count     (res_count),
        .out_fill_flag (res_fill)
    );

    // Pack the result: mean in the low half, count above it, zero padding on top.
    assign m_tdata = {3'b000, res_count, res_mean};
    assign m_tuser = res_fill;

endmodule

`default_nettype wire

/* dv/masked_cell_mean_with_coverage_top_tb.sv */
// Self-checking testbench for masked_cell_mean_with_coverage_top: streams depth cells,
// predicts each cell mean in a local model and compares every result field.
// Depends on mcm_pkg and masked_cell_mean_with_coverage_top.
`timescale 1ns / 1ps

module masked_cell_mean_with_coverage_top_tb;
    import mcm_pkg::*;

    // Run control. The slowest correct run (one saturated and one nearly full cell,
    // ~600 random requests with gaps, a result per short cell and every result
    // stalled) stays far below the cycle limit.
    localparam int CELL_LIMIT   = MAX_CELL_SAMPLES_DEF;
    localparam int SUM_W        = 29;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASE_ITEMS  = 85;
    localparam int DIR_ROWS     = 23;

    // Index 3 lies past the register list; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean;
        logic [COUNT_W-1:0]         count;
        logic                       fill;
    } cell_result_t;

    // One row of the directed table. Rows with typed set carry their result
    // written out by hand; the others are left to the predictor.
    typedef struct packed {
        logic [SAMPLE_W-1:0] depth;
        logic                last;
        logic                empty;
        logic                typed;
        cell_result_t        res;
    } dir_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Local copy of the configuration and of the running cell state.
    logic signed [SAMPLE_W-1:0] in_fill  = IN_FILL_RST;
    logic signed [SAMPLE_W-1:0] out_fill = OUT_FILL_RST;
    logic [PERMILLE_W-1:0]      keep     = KEEP_RST;
    logic signed [SUM_W-1:0]    acc_sum  = '0;
    logic [COUNT_W-1:0]         valid_n  = '0;
    logic [COUNT_W-1:0]         seen_n   = '0;

    cell_result_t pending_cells[$];

    int  err_count     = 0;
    int  sent_count    = 0;
    int  checked_cells = 0;
    int  setting_count = 1;
    int  cycle_count   = 0;
    bit  tx_idle_on    = 1'b1;
    bit  rx_idle_on    = 1'b1;
    bit  rx_long_hold  = 1'b0;

    // Directed cases, all under the reset settings (input fill -32768,
    // output fill -32767, keep 900 per mille).
    dir_row_t dir_table [DIR_ROWS] = '{
        // The empty mark wins over the last flag and ignores the sample.
        '{16'h7FFF, 1'b1, 1'b1, 1'b1, '{OUT_FILL_RST, 13'd0, 1'b1}},
        // Single-sample cells: valid value nearest zero, input fill code,
        // largest positive value, zero and the most negative valid value.
        '{-16'sd1, 1'b1, 1'b0, 1'b1, '{-16'sd1, 13'd1, 1'b0}},
        '{IN_FILL_RST, 1'b1, 1'b0, 1'b1, '{OUT_FILL_RST, 13'd0, 1'b1}},
        '{16'sd32767, 1'b1, 1'b0, 1'b1, '{OUT_FILL_RST, 13'd0, 1'b1}},
        '{16'sd0, 1'b1, 1'b0, 1'b1, '{OUT_FILL_RST, 13'd0, 1'b1}},
        '{-16'sd32767, 1'b1, 1'b0, 1'b1, '{-16'sd32767, 13'd1, 1'b0}},
        // Mean of -11 over three truncates toward zero.
        '{-16'sd3, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd4, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd4, 1'b1, 1'b0, 1'b0, '0},
        // A partly gathered cell is dropped by an empty mark.
        '{-16'sd5, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd7, 1'b0, 1'b1, 1'b1, '{OUT_FILL_RST, 13'd0, 1'b1}},
        // Nine valid of ten sits exactly on the 900 per mille threshold.
        '{-16'sd10, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd20, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd30, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd40, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd50, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd60, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd70, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd80, 1'b0, 1'b0, 1'b0, '0},
        '{-16'sd90, 1'b0, 1'b0, 1'b0, '0},
        '{16'sd5, 1'b1, 1'b0, 1'b0, '0},
        // One valid of two is low coverage: fill, but the count is kept.
        '{-16'sd9, 1'b0, 1'b0, 1'b0, '0},
        '{16'sd1, 1'b1, 1'b0, 1'b1, '{OUT_FILL_RST, 13'd1, 1'b1}}
    };

    masked_cell_mean_with_coverage_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever begin
            #10 aclk = ~aclk;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Advances the cell state by one accepted request. Returns 1 when the
    // request closes a cell, with the expected result in res.
    function automatic bit cell_mean_step(input logic signed [SAMPLE_W-1:0] depth,
                                          input logic last, input logic empty,
                                          output cell_result_t res);
        logic [23:0] have;
        logic [23:0] need;
        longint      quo;
        res = '0;
        if (empty) begin
            acc_sum = '0;
            valid_n = '0;
            seen_n  = '0;
            res = '{out_fill, '0, 1'b1};
            return 1'b1;
        end
        // Samples past the cell limit are neither counted nor summed.
        if (seen_n < CELL_LIMIT) begin
            seen_n = seen_n + 1'b1;
            if (depth < 0 && depth != in_fill) begin
                acc_sum = acc_sum + SUM_W'(depth);
                valid_n = valid_n + 1'b1;
            end
        end
        if (!last) begin
            return 1'b0;
        end
        // Exact integer coverage test: valid * 1000 against keep * total.
        have = 24'(valid_n) * 24'd1000;
        need = 24'(keep) * 24'(seen_n);
        if (valid_n == 0) begin
            res = '{out_fill, '0, 1'b1};
        end else if (have < need) begin
            res = '{out_fill, valid_n, 1'b1};
        end else begin
            quo = longint'(acc_sum) / longint'(valid_n);
            res = '{SAMPLE_W'(quo), valid_n, 1'b0};
        end
        acc_sum = '0;
        valid_n = '0;
        seen_n  = '0;
        return 1'b1;
    endfunction

    // Offers one sample request after a random gap and waits for it to be
    // taken. s_tvalid stays high afterwards so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_request(input logic [SAMPLE_W-1:0] depth, input logic last,
                                input logic empty, input bit typed,
                                input cell_result_t typed_res);
        int           gap;
        cell_result_t res;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= depth;
        s_tlast  <= last;
        s_tuser  <= empty;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
        if (cell_mean_step(depth, last, empty, res)) begin
            pending_cells.push_back(typed ? typed_res : res);
        end
    endtask

    // Sends one cell of random samples; valid_pct sets how many are valid.
    // A broken cell ends in an empty mark instead of a last flag.
    task automatic send_random_cell(input int len, input int valid_pct, input bit broken);
        logic [SAMPLE_W-1:0] depth;
        int                  pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < valid_pct) begin
                depth = SAMPLE_W'(-$urandom_range(1, 32768));
            end else if (pick < valid_pct + (100 - valid_pct) / 3) begin
                depth = in_fill;
            end else begin
                case ($urandom_range(0, 3))
                    0: depth = '0;
                    1: depth = SAMPLE_W'($urandom_range(1, 32767));
                    default: depth = SAMPLE_W'($urandom);
                endcase
            end
            if (broken && i == len - 1) begin
                send_request(depth, 1'($urandom), 1'b1, 1'b0, '0);
            end else begin
                send_request(depth, i == len - 1, 1'b0, 1'b0, '0);
            end
        end
    endtask

    // Stops offering, waits for every pending result and then for the
    // divider latency, so that nothing is left in flight.
    task automatic drain_results;
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // One register write request; cfg_valid is lowered by the caller.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_IN_FILL:  in_fill  = data;
            CFG_OUT_FILL: out_fill = data;
            CFG_KEEP:     keep     = data[PERMILLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] in_code,
                                  input logic [CFG_DATA_W-1:0] out_code,
                                  input logic [CFG_DATA_W-1:0] keep_word,
                                  input bit poke_unused);
        drain_results();
        if (poke_unused) begin
            write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        end
        write_reg(CFG_IN_FILL, in_code);
        write_reg(CFG_OUT_FILL, out_code);
        write_reg(CFG_KEEP, keep_word);
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // Random settings: the input fill code is mostly negative so that it
    // actually masks samples, and the threshold mostly sits near the
    // coverage the random cells produce.
    task automatic apply_random_settings(input bit poke_unused);
        logic [CFG_DATA_W-1:0] in_code;
        logic [CFG_DATA_W-1:0] keep_word;
        in_code = ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(-$urandom_range(1, 32768))
                                              : CFG_DATA_W'($urandom);
        keep_word = ($urandom_range(0, 9) < 7) ? CFG_DATA_W'($urandom_range(700, 1000))
                                               : CFG_DATA_W'($urandom_range(0, 1023));
        apply_settings(in_code, CFG_DATA_W'($urandom), keep_word, poke_unused);
    endtask

    // Random traffic: mostly well-formed cells of random length and
    // coverage, with stray empty marks and cells cut short by an empty mark.
    task automatic run_random(input int n_items);
        int start;
        int r;
        int len;
        int pct;
        start = sent_count;
        while (sent_count - start < n_items) begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0: pct = 100;
                1: pct = 95;
                2: pct = 90;
                3: pct = 75;
                4: pct = 50;
                default: pct = $urandom_range(0, 100);
            endcase
            if (r < 6) begin
                send_request(SAMPLE_W'($urandom), 1'($urandom), 1'b1, 1'b0, '0);
            end else if (r < 10) begin
                send_random_cell(len, pct, 1'b1);
            end else begin
                send_random_cell(len, pct, 1'b0);
            end
        end
    endtask

    // Result side: random back-pressure per result, and one long hold-off
    // when requested so that the output register and divider back up into
    // the sample input.
    initial begin
        int           gap;
        cell_result_t want;
        cell_result_t got;
        wait (aresetn);
        forever begin
            if (rx_long_hold) begin
                gap = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, 4) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = '{m_tdata[15:0], m_tdata[28:16], m_tuser[0]};
            if (pending_cells.size() == 0) begin
                $error("Result with no cell pending: mean %0d, count %0d, fill %0d",
                       got.mean, got.count, got.fill);
                err_count++;
            end else begin
                want = pending_cells.pop_front();
                checked_cells++;
                if (got.mean !== want.mean) begin
                    $error("mean_depth: expected %0d, got %0d", want.mean, got.mean);
                    err_count++;
                end
                if (got.count !== want.count) begin
                    $error("valid_count: expected %0d, got %0d", want.count, got.count);
                    err_count++;
                end
                if (got.fill !== want.fill) begin
                    $error("is_fill: expected %0d, got %0d", want.fill, got.fill);
                    err_count++;
                end
                if (m_tdata[31:29] !== 3'd0) begin
                    $error("tdata padding: expected 0, got %0d", m_tdata[31:29]);
                    err_count++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table under the reset settings.
        for (int i = 0; i < DIR_ROWS; i++) begin
            send_request(dir_table[i].depth, dir_table[i].last, dir_table[i].empty,
                         dir_table[i].typed, dir_table[i].res);
        end

        // Two large cells without idling: one fully valid and past the
        // sample limit, one just under it with a few invalid samples.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random_cell(CELL_LIMIT + 4, 100, 1'b0);
        send_random_cell(CELL_LIMIT - 1, 97, 1'b0);

        // Extremes: an all-ones input fill code, the largest positive output fill and
        // keep 1000, with the upper data bits set to show the threshold register is 10 bits.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        apply_settings(16'hFFFF, 16'h7FFF, 16'hFC00 | 16'd1000, 1'b0);
        run_random(PHASE_ITEMS);

        // Opposite extremes: positive input fill, most negative output fill,
        // and no coverage requirement. No idling on either side.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        apply_settings(16'h7FFF, 16'h8000, 16'd0, 1'b0);
        run_random(PHASE_ITEMS);

        // Threshold above 1000 makes every cell fill; also a write to an
        // index past the register list, which must have no effect.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        apply_settings(CFG_DATA_W'(-$urandom_range(1, 32768)), CFG_DATA_W'($urandom),
                       16'd1023, 1'b1);
        run_random(PHASE_ITEMS);

        // Long output stall while the sender keeps offering short cells.
        apply_random_settings(1'b1);
        tx_idle_on = 1'b0;
        rx_long_hold = 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_random_cell($urandom_range(1, 3), 90, 1'b0);
        end
        tx_idle_on = 1'b1;
        run_random(PHASE_ITEMS);

        // Sender pauses halfway until every result is back.
        apply_random_settings(1'b0);
        run_random(PHASE_ITEMS / 2);
        drain_results();
        run_random(PHASE_ITEMS / 2);

        apply_random_settings(1'b0);
        rx_idle_on = 1'b0;
        run_random(PHASE_ITEMS);

        apply_random_settings(1'b0);
        rx_idle_on = 1'b1;
        run_random(PHASE_ITEMS);

        drain_results();

        $display("Checked %0d cell results from %0d sample requests over %0d register settings,",
                 checked_cells, sent_count, setting_count);
        $display("including saturated cells, empty marks, dropped cells and a long output stall.");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/mcm_pkg.sv
rtl/mcm_ctrl.sv
rtl/mcm_datapath.sv
rtl/masked_cell_mean_with_coverage_top.sv
dv/masked_cell_mean_with_coverage_top_tb.sv
